// ===== hdl/iale_pkg.sv =====
// Package for the indexed array list engine.
// Holds field widths, operation codes, controller states and the
// command/status structs shared by the controller and the datapath.
package iale_pkg;

  localparam int unsigned OP_W           = 3;
  localparam int unsigned POS_W          = 5;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned CNT_W          = 5;
  localparam int unsigned IN_TDATA_W     = 40;
  localparam int unsigned OUT_TDATA_W    = 48;
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_SEARCH  = 3'd2,
    OP_SELECT  = 3'd3,
    OP_REPLACE = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_LOOP,
    ST_INS_WR,
    ST_INS_PUT,
    ST_REM_LOOP,
    ST_REM_WR,
    ST_SCAN_LOOP,
    ST_SCAN_CHK,
    ST_SEL_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [2:0] {
    RD_IDX_M1,
    RD_IDX_P1,
    RD_IDX,
    RD_POS,
    RD_CNT_M1
  } rd_sel_e;

  typedef enum logic {
    WR_SHIFT,
    WR_VALUE
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    idx_op_e idx_op;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_ok;
    logic    found_cnt;
    logic    found_idx;
    logic    take_rd;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ins_ok;
    logic            pos_lt_cnt;
    logic            cnt_nz;
    logic            idx_gt_pos;
    logic            idx1_lt_cnt;
    logic            idx_lt_cnt;
    logic            match;
    logic            out_free;
  } status_t;

endpackage

// ===== hdl/iale_ctrl.sv =====
// Controller of the indexed array list engine.
// Sequences each request through memory reads, shifts and scans.
// Depends on iale_pkg; drives the datapath through cmd_t, reads status_t.
module iale_ctrl
  import iale_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.idx_op = IDX_HOLD;
    cmd_o.rd_sel = RD_IDX;
    cmd_o.wr_sel = WR_SHIFT;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_d = ST_DONE;
        unique case (op_e'(sts_i.op))
          OP_INSERT: begin
            if (sts_i.ins_ok) begin
              cmd_o.idx_op = IDX_CNT;
              state_d      = ST_INS_LOOP;
            end
          end
          OP_REMOVE: begin
            if (sts_i.pos_lt_cnt) begin
              cmd_o.idx_op = IDX_POS;
              state_d      = ST_REM_LOOP;
            end
          end
          OP_SEARCH: begin
            cmd_o.found_cnt = 1'b1;
            cmd_o.idx_op    = IDX_ZERO;
            state_d         = ST_SCAN_LOOP;
          end
          OP_SELECT: begin
            if (sts_i.pos_lt_cnt) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_POS;
              cmd_o.set_ok = 1'b1;
              state_d      = ST_SEL_WAIT;
            end else if (sts_i.cnt_nz) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_CNT_M1;
              state_d      = ST_SEL_WAIT;
            end
          end
          OP_REPLACE: begin
            if (sts_i.pos_lt_cnt) begin
              cmd_o.wr_en  = 1'b1;
              cmd_o.wr_sel = WR_VALUE;
              cmd_o.set_ok = 1'b1;
            end
          end
          default: ;
        endcase
      end

      ST_INS_LOOP: begin
        if (sts_i.idx_gt_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_M1;
          state_d      = ST_INS_WR;
        end else begin
          state_d = ST_INS_PUT;
        end
      end

      ST_INS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_DEC;
        state_d      = ST_INS_LOOP;
      end

      ST_INS_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_VALUE;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.set_ok  = 1'b1;
        state_d       = ST_DONE;
      end

      ST_REM_LOOP: begin
        if (sts_i.idx1_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX_P1;
          state_d      = ST_REM_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.set_ok  = 1'b1;
          state_d       = ST_DONE;
        end
      end

      ST_REM_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_INC;
        state_d      = ST_REM_LOOP;
      end

      ST_SCAN_LOOP: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX;
          state_d      = ST_SCAN_CHK;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_SCAN_CHK: begin
        if (sts_i.match) begin
          cmd_o.found_idx = 1'b1;
          cmd_o.set_ok    = 1'b1;
          state_d         = ST_DONE;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = ST_SCAN_LOOP;
        end
      end

      ST_SEL_WAIT: begin
        cmd_o.take_rd = 1'b1;
        state_d       = ST_DONE;
      end

      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/iale_dp.sv =====
// Datapath of the indexed array list engine.
// Holds the entry memory, request and result registers and the output stage.
// Depends on iale_pkg; steered by the controller through cmd_t.
module iale_dp
  import iale_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  cmd_t                   cmd_i,
  output status_t                sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_q;

  logic [OP_W-1:0]       op_q;
  logic [CMPW-1:0]       pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  ok_q;
  logic [CW-1:0]         found_q;
  logic [DATA_WIDTH-1:0] rd_q;

  logic                  out_valid_q;
  logic                  out_ok_q;
  logic [POS_W-1:0]      out_found_q;
  logic [VAL_W-1:0]      out_rd_q;
  logic [CNT_W-1:0]      out_cnt_q;
  logic                  out_empty_q;
  logic                  out_full_q;

  logic signed [VAL_W-1:0] in_val;
  logic [CW-1:0]           raddr_full;
  logic [CW-1:0]           waddr_full;
  logic [DATA_WIDTH-1:0]   wdata;
  logic [CMPW-1:0]         cnt_x, idx_x;

  assign in_val = in_data_i[IN_TDATA_W-1:OP_W+POS_W];
  assign cnt_x  = CMPW'(cnt_q);
  assign idx_x  = CMPW'(idx_q);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX_M1: raddr_full = idx_q - CW'(1);
      RD_IDX_P1: raddr_full = idx_q + CW'(1);
      RD_IDX:    raddr_full = idx_q;
      RD_POS:    raddr_full = CW'(pos_q);
      RD_CNT_M1: raddr_full = cnt_q - CW'(1);
      default:   raddr_full = idx_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_SHIFT: begin
        waddr_full = idx_q;
        wdata      = rdata_q;
      end
      WR_VALUE: begin
        waddr_full = CW'(pos_q);
        wdata      = val_q;
      end
      default: begin
        waddr_full = idx_q;
        wdata      = rdata_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[waddr_full[AW-1:0]] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr_full[AW-1:0]];
    end
  end

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_HOLD: idx_d = idx_q;
      IDX_CNT:  idx_d = cnt_q;
      IDX_POS:  idx_d = CW'(pos_q);
      IDX_ZERO: idx_d = '0;
      IDX_INC:  idx_d = idx_q + CW'(1);
      IDX_DEC:  idx_d = idx_q - CW'(1);
      default:  idx_d = idx_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.load) begin
      op_q    <= in_data_i[OP_W-1:0];
      pos_q   <= CMPW'(in_data_i[OP_W+POS_W-1:OP_W]);
      val_q   <= DATA_WIDTH'(in_val);
      ok_q    <= 1'b0;
      found_q <= '0;
      rd_q    <= '0;
    end else begin
      if (cmd_i.set_ok) begin
        ok_q <= 1'b1;
      end
      if (cmd_i.found_cnt) begin
        found_q <= cnt_q;
      end else if (cmd_i.found_idx) begin
        found_q <= idx_q;
      end
      if (cmd_i.take_rd) begin
        rd_q <= rdata_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ok_q    <= ok_q;
      out_found_q <= POS_W'(found_q);
      out_rd_q    <= VAL_W'(rd_q);
      out_cnt_q   <= CNT_W'(cnt_q);
      out_empty_q <= (cnt_q == '0);
      out_full_q  <= (cnt_q == CW'(CAPACITY));
    end
  end

  assign sts_o.op          = op_q;
  assign sts_o.ins_ok      = (cnt_q != CW'(CAPACITY)) && (pos_q <= cnt_x);
  assign sts_o.pos_lt_cnt  = (pos_q < cnt_x);
  assign sts_o.cnt_nz      = (cnt_q != '0);
  assign sts_o.idx_gt_pos  = (idx_x > pos_q);
  assign sts_o.idx1_lt_cnt = ((idx_x + CMPW'(1)) < cnt_x);
  assign sts_o.idx_lt_cnt  = (idx_q < cnt_q);
  assign sts_o.match       = (rdata_q == val_q);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {3'b000, out_full_q, out_empty_q, out_cnt_q,
                        out_rd_q, out_found_q, out_ok_q};

endmodule

// ===== hdl/indexed_array_list_engine.sv =====
// Indexed array list engine: bounded ordered list with insert, remove,
// search, select and replace; one result per request, one request at a time.
// Entries are shifted one at a time, each read and then written back. A new request
// can be taken in the cycle after its result is loaded. Reset empties the list.
module indexed_array_list_engine
  import iale_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // op[2:0], position[7:3], value[39:8]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // ok[0], found_position[5:1], read_value[37:6], count[42:38],
  // is_empty[43], is_full[44], zero[47:45]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  cmd_t    cmd;
  status_t sts;

  iale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iale_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// ===== sim/list_result_checker.sv =====
// Checker for the indexed array list engine: watches the request and result
// streams, keeps its own copy of the list and compares every result.
// Depends on iale_pkg for the stream widths and operation codes.
module list_result_checker
  import iale_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  // op[2:0], position[7:3], value[39:8]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  // ok[0], found_position[5:1], read_value[37:6], count[42:38],
  // is_empty[43], is_full[44], zero[47:45]
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  output int                     errors_o,
  output int                     pending_o,
  output int                     checked_o,
  output int                     full_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP = CAPACITY_DEF;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] read_val;
    logic [POS_W-1:0] found_pos;
    logic             ok;
  } list_result_t;

  logic [VAL_W-1:0] list_q [LIST_CAP];
  int               list_len;
  list_result_t     expected_results_q [$];
  list_result_t     want_r;
  list_result_t     seen_r;
  int               err_n;
  int               checked_n;
  int               full_n;

  function automatic list_result_t list_update(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                               logic [VAL_W-1:0] val);
    list_result_t r;
    int           at;
    int           i;
    r  = '0;
    at = int'(pos);
    case (op)
      OP_INSERT: begin
        if (list_len < LIST_CAP && at <= list_len) begin
          for (i = list_len; i > at; i--) list_q[i] = list_q[i-1];
          list_q[at] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (at < list_len) begin
          for (i = at; i + 1 < list_len; i++) list_q[i] = list_q[i+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      OP_SEARCH: begin
        r.found_pos = POS_W'(list_len);
        // scan downward so the lowest matching position wins
        for (i = list_len - 1; i >= 0; i--) begin
          if (list_q[i] == val) begin
            r.found_pos = POS_W'(i);
            r.ok        = 1'b1;
          end
        end
      end
      OP_SELECT: begin
        if (at < list_len) begin
          r.read_val = list_q[at];
          r.ok       = 1'b1;
        end else if (list_len > 0) begin
          r.read_val = list_q[list_len-1];
        end
      end
      OP_REPLACE: begin
        if (at < list_len) begin
          list_q[at] = val;
          r.ok       = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(list_len);
    r.empty = (list_len == 0);
    r.full  = (list_len == LIST_CAP);
    return r;
  endfunction

  function automatic int field_mismatch(string field, logic [VAL_W-1:0] want,
                                        logic [VAL_W-1:0] seen);
    if (want == seen) return 0;
    $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, seen);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LIST_CAP; i++) list_q[i] = '0;
      list_len  = 0;
      err_n     = 0;
      checked_n = 0;
      full_n    = 0;
      expected_results_q.delete();
      errors_o    <= 0;
      pending_o   <= 0;
      checked_o   <= 0;
      full_seen_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen_r = m_axis_tdata_i[$bits(list_result_t)-1:0];
        if (expected_results_q.size() == 0) begin
          $error("result transfer with no request outstanding: 0x%0h", m_axis_tdata_i);
          err_n++;
        end else begin
          want_r = expected_results_q.pop_front();
          err_n += field_mismatch("ok", VAL_W'(want_r.ok), VAL_W'(seen_r.ok));
          err_n += field_mismatch("found_position", VAL_W'(want_r.found_pos),
                                  VAL_W'(seen_r.found_pos));
          err_n += field_mismatch("read_value", want_r.read_val, seen_r.read_val);
          err_n += field_mismatch("count", VAL_W'(want_r.count), VAL_W'(seen_r.count));
          err_n += field_mismatch("is_empty", VAL_W'(want_r.empty), VAL_W'(seen_r.empty));
          err_n += field_mismatch("is_full", VAL_W'(want_r.full), VAL_W'(seen_r.full));
          checked_n++;
          if (want_r.full) full_n++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_results_q.push_back(list_update(s_axis_tdata_i[OP_W-1:0],
                                                 s_axis_tdata_i[OP_W +: POS_W],
                                                 s_axis_tdata_i[OP_W+POS_W +: VAL_W]));
      end
      errors_o    <= err_n;
      pending_o   <= expected_results_q.size();
      checked_o   <= checked_n;
      full_seen_o <= full_n;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the indexed array list engine testbench: clock, reset, request
// stimulus and result back-pressure around the engine and its checker.
// Depends on iale_pkg, indexed_array_list_engine and list_result_checker.
module tb_top
  import iale_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS  = 310;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // op[2:0], position[7:3], value[39:8]
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // ok[0], found_position[5:1], read_value[37:6], count[42:38],
  // is_empty[43], is_full[44], zero[47:45]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int               errors;
  int               pending;
  int               checked;
  int               full_seen;
  int               cycle_n = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               ops_sent [2**OP_W];
  logic [VAL_W-1:0] value_pool [8];

  indexed_array_list_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  list_result_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .errors_o        (errors),
    .pending_o       (pending),
    .checked_o       (checked),
    .full_seen_o     (full_seen)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_n, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40) return value_pool[$urandom_range(7)];
    if (r < 55) begin
      case ($urandom_range(3))
        0: return {1'b1, {(VAL_W-1){1'b0}}};
        1: return {1'b0, {(VAL_W-1){1'b1}}};
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, pos, op};
    do @(posedge clk_i); while (!s_axis_tready);
    ops_sent[op]++;
    if (op == OP_INSERT || op == OP_REPLACE) value_pool[$urandom_range(7)] = val;
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
    mix_e             mix;
    int               left;
    int               w_ins;
    int               w_rem;
    int               r;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    mix  = MIX_FILL;
    left = 48;
    for (int n = 0; n < items; n++) begin
      if (left == 0) begin
        mix  = mix_e'($urandom_range(2));
        left = $urandom_range(16, 64);
      end
      left--;
      w_ins = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 8 : 25;
      w_rem = (mix == MIX_FILL) ? 5 : (mix == MIX_DRAIN) ? 60 : 22;
      r = $urandom_range(99);
      if (r < 5) begin
        op = OP_W'(OP_REPLACE + $urandom_range(1, 2**OP_W - 1 - OP_REPLACE));
      end else if (r < 5 + w_ins) begin
        op = OP_INSERT;
      end else if (r < 5 + w_ins + w_rem) begin
        op = OP_REMOVE;
      end else begin
        case ($urandom_range(2))
          0: op = OP_SEARCH;
          1: op = OP_SELECT;
          default: op = OP_REPLACE;
        endcase
      end
      r = $urandom_range(99);
      if (r < 8) pos = POS_W'($urandom_range(CAPACITY_DEF + 1, 2**POS_W - 1));
      else if (r < 50) pos = POS_W'($urandom_range(3));
      else pos = POS_W'($urandom_range(CAPACITY_DEF));
      send_request(op, pos, pick_value());
      if ($urandom_range(59) == 0) hold_until_drained();
    end
    hold_until_drained();
  endtask

  initial begin
    int undef_n;
    undef_n = 0;
    foreach (ops_sent[i]) ops_sent[i] = 0;
    value_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                   32'h1234_5678, 32'h1, 32'hDEAD_BEEF, 32'h5555_AAAA};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty list corners
    send_request(OP_SEARCH, 5'd0, 32'h0);
    send_request(OP_SELECT, 5'd0, 32'h0);
    send_request(OP_REMOVE, 5'd0, 32'h0);
    send_request(OP_REPLACE, 5'd0, 32'h1);
    send_request(OP_INSERT, 5'd1, 32'h1);
    // build, append and insert in the middle
    send_request(OP_INSERT, 5'd0, 32'h8000_0000);
    send_request(OP_INSERT, 5'd1, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 5'd1, 32'h0);
    send_request(OP_SELECT, 5'd2, 32'h0);
    send_request(OP_SELECT, 5'd31, 32'hFFFF_FFFF);
    send_request(OP_SEARCH, 5'd0, 32'h7FFF_FFFF);
    send_request(OP_SEARCH, 5'd31, 32'h1234_5678);
    send_request(OP_REPLACE, 5'd3, 32'h1234_5678);
    send_request(OP_REPLACE, 5'd4, 32'h0);
    send_request(OP_REMOVE, 5'd4, 32'h0);
    send_request(OP_REMOVE, 5'd1, 32'h0);
    for (int k = OP_REPLACE + 1; k < 2**OP_W; k++) begin
      send_request(OP_W'(k), 5'd31, 32'hFFFF_FFFF);
    end
    send_request(OP_SEARCH, 5'd0, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 5'd0, 32'h0);
    send_request(OP_INSERT, 5'd31, 32'h0);
    hold_until_drained();

    run_phase(PHASE_ITEMS, 0, 0);
    run_phase(PHASE_ITEMS, 71, 0);
    run_phase(PHASE_ITEMS, 0, 71);
    run_phase(PHASE_ITEMS, 33, 33);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    for (int k = OP_REPLACE + 1; k < 2**OP_W; k++) undef_n += ops_sent[k];
    $display("checked %0d results: %0d insert, %0d remove, %0d search, %0d select, %0d replace,",
             checked, ops_sent[OP_INSERT], ops_sent[OP_REMOVE], ops_sent[OP_SEARCH],
             ops_sent[OP_SELECT], ops_sent[OP_REPLACE]);
    $display("%0d undefined ops; idle mixes none/sender/receiver/both; list full in %0d results",
             undef_n, full_seen);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
